// ----- src/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg - shared types and constants of the multipart boundary scanner
// Byte and hash widths, marker constants, register indexes and the result
// command that the scan controller hands to the result stage.
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int BYTE_W               = 8;
   localparam int HASH_W               = 32;
   localparam int LEN_W                = 6;
   localparam int CSR_IDX_W            = 1;
   localparam int DEF_MAX_BOUNDARY_LEN = 56;

   // CR LF '-' '-' as it sits in the window, oldest byte on top
   localparam logic [HASH_W-1:0] MARKER      = 32'h0d0a2d2d;
   // CR LF preloaded so that a boundary at the very start is found
   localparam logic [HASH_W-1:0] WINDOW_INIT = 32'h000d0a00;
   // 40^4 + 40^3 + 40^2 + 40 + 1
   localparam logic [HASH_W-1:0] HASH_MUL    = 32'd2625641;

   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_HASH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_LEN  = 1'b1;

   // one result command: emit pushes a result, close ends the current item
   typedef struct packed {
      logic              emit;
      logic              close;
      logic [BYTE_W-1:0] out_byte;
      logic              is_boundary;
   } mbs_emit_type;

   // byte idx of the marker, first byte at idx 0
   function automatic logic [BYTE_W-1:0] mbs_marker_byte(input logic [1:0] idx);
      logic [HASH_W-1:0] sh;
      sh = MARKER >> {~idx, 3'b000};
      return sh[BYTE_W-1:0];
   endfunction

endpackage

// ----- src/multipart_boundary_scanner_core.sv -----
// ----------------------------------------------------------------------------
// multipart_boundary_scanner_core - multipart body boundary scanner
// Bytes of a request body go in on req_*, one per item; req_tlast marks the
// last body byte. Each input item gives zero or more results on rsp_*:
// a payload byte (rsp_tuser low) or a boundary hit (rsp_tuser high), and
// rsp_tlast is high on the final result of that input item.
// The csr_* port sets the expected boundary hash (index 0) and the boundary
// length (index 1); write it only while no item is in flight.
// While scanning or collecting, input bytes are taken back to back as long as
// the result stage has room. A hash mismatch first releases the marker (its
// first byte with the mismatch, the rest from ST_MARK), then rescans each
// candidate byte by a read of the candidate memory (ST_RD) and a step (ST_RP).
// The end of body goes through ST_FIN, then ST_FHELD for each held byte, or
// the pending marker and candidates, and ST_CLOSE.
// A result on rsp_* comes from the output register; it is first kept in the
// hold register while it is not yet known whether it ends its item.
// Reset clears the scan state (window preloaded with CR LF), sets the hash
// to 0 and the length to 1. A stalled rsp_tready holds the output register
// and backs up into req_tready; no result is lost.
// ----------------------------------------------------------------------------
module multipart_boundary_scanner_core #(
   parameter int MAX_BOUNDARY_LEN = mbs_pkg::DEF_MAX_BOUNDARY_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mbs_pkg::BYTE_W-1:0]    req_tdata,   // data_byte
   input  logic                          req_tlast,   // end_of_body
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mbs_pkg::BYTE_W-1:0]    rsp_tdata,   // out_byte
   output logic                          rsp_tuser,   // is_boundary
   output logic                          rsp_tlast,   // last_of_run
   input  logic                          csr_we,
   input  logic [mbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbs_pkg::HASH_W-1:0]    csr_wdata
);
   import mbs_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOUNDARY_LEN + 1);

   logic [HASH_W-1:0] bhash_ff, bhash_in;
   logic [CNT_W-1:0]  elen_ff, elen_in;
   logic [LEN_W-1:0]  len_raw;
   mbs_emit_type      cmd;
   logic              room;

   // clamp the length at write time: zero acts as one, large as the maximum
   always_comb begin
      len_raw  = csr_wdata[LEN_W-1:0];
      bhash_in = bhash_ff;
      elen_in  = elen_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BOUNDARY_HASH: bhash_in = csr_wdata;
            CSR_BOUNDARY_LEN: begin
               if (len_raw == '0) begin
                  elen_in = CNT_W'(1);
               end else if (len_raw > LEN_W'(MAX_BOUNDARY_LEN)) begin
                  elen_in = CNT_W'(MAX_BOUNDARY_LEN);
               end else begin
                  elen_in = CNT_W'(len_raw);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bhash_ff <= '0;
         elen_ff  <= CNT_W'(1);
      end else begin
         bhash_ff <= bhash_in;
         elen_ff  <= elen_in;
      end
   end

   mbs_scan_ctrl #(
      .MAX_BOUNDARY_LEN (MAX_BOUNDARY_LEN),
      .CNT_W            (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .bnd_hash   (bhash_ff),
      .eff_len    (elen_ff),
      .room       (room),
      .cmd        (cmd)
   );

   mbs_result_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/mbs_cand_mem.sv -----
// ----------------------------------------------------------------------------
// mbs_cand_mem - candidate byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mbs_cand_mem #(
   parameter int ADDR_W = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [mbs_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [mbs_pkg::BYTE_W-1:0] rd_data
);
   import mbs_pkg::*;

   logic [BYTE_W-1:0] mem_ff [2**ADDR_W];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mbs_result_stage.sv -----
// ----------------------------------------------------------------------------
// mbs_result_stage - result hold and output register
// Keeps the newest result back until it is known whether it ends its item,
// so that the last flag is right, and drives the result channel.
// ----------------------------------------------------------------------------
module mbs_result_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  mbs_pkg::mbs_emit_type      cmd,
   output logic                       room,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mbs_pkg::BYTE_W-1:0] rsp_tdata,   // out_byte
   output logic                       rsp_tuser,   // is_boundary
   output logic                       rsp_tlast    // last_of_run
);
   import mbs_pkg::*;

   logic              hold_vld_ff, hold_vld_in;
   logic              hclose_ff, hclose_in;
   logic [BYTE_W-1:0] hold_byte_ff, hold_byte_in;
   logic              hold_bnd_ff, hold_bnd_in;
   logic              out_vld_ff, out_vld_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_bnd_ff, out_bnd_in;
   logic              out_last_ff, out_last_in;
   logic              free;

   always_comb begin
      free         = !out_vld_ff || rsp_tready;
      room         = free && !hclose_ff;
      hold_vld_in  = hold_vld_ff;
      hclose_in    = hclose_ff;
      hold_byte_in = hold_byte_ff;
      hold_bnd_in  = hold_bnd_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_bnd_in   = out_bnd_ff;
      out_last_in  = out_last_ff;
      if (hclose_ff) begin
         // drain the held result as the last one of its item
         if (free) begin
            out_vld_in  = 1'b1;
            out_byte_in = hold_byte_ff;
            out_bnd_in  = hold_bnd_ff;
            out_last_in = 1'b1;
            hold_vld_in = 1'b0;
            hclose_in   = 1'b0;
         end
      end else if (cmd.emit) begin
         if (hold_vld_ff) begin
            out_vld_in   = 1'b1;
            out_byte_in  = hold_byte_ff;
            out_bnd_in   = hold_bnd_ff;
            out_last_in  = 1'b0;
            hold_byte_in = cmd.out_byte;
            hold_bnd_in  = cmd.is_boundary;
            hclose_in    = cmd.close;
         end else if (cmd.close) begin
            out_vld_in  = 1'b1;
            out_byte_in = cmd.out_byte;
            out_bnd_in  = cmd.is_boundary;
            out_last_in = 1'b1;
         end else begin
            hold_vld_in  = 1'b1;
            hold_byte_in = cmd.out_byte;
            hold_bnd_in  = cmd.is_boundary;
         end
      end else if (cmd.close && hold_vld_ff) begin
         out_vld_in  = 1'b1;
         out_byte_in = hold_byte_ff;
         out_bnd_in  = hold_bnd_ff;
         out_last_in = 1'b1;
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         hclose_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         hclose_ff   <= hclose_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_bnd_ff  <= hold_bnd_in;
      out_byte_ff  <= out_byte_in;
      out_bnd_ff   <= out_bnd_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_bnd_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- src/mbs_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbs_scan_ctrl - marker scan, candidate hashing, replay and flush
// Candidates live in a circular memory. After a mismatch the queue of bytes
// to rescan is a contiguous range of that memory, read back one byte at a
// time; a marker found inside it just moves the candidate start pointer.
// ----------------------------------------------------------------------------
module mbs_scan_ctrl #(
   parameter int MAX_BOUNDARY_LEN = mbs_pkg::DEF_MAX_BOUNDARY_LEN,
   parameter int CNT_W            = $clog2(MAX_BOUNDARY_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [mbs_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic [mbs_pkg::HASH_W-1:0] bnd_hash,
   input  logic [CNT_W-1:0]           eff_len,
   input  logic                       room,
   output mbs_pkg::mbs_emit_type      cmd
);
   import mbs_pkg::*;

   localparam int ADDR_W = (MAX_BOUNDARY_LEN > 1) ? $clog2(MAX_BOUNDARY_LEN) : 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MARK  = 7'b0000010,
      ST_RD    = 7'b0000100,
      ST_RP    = 7'b0001000,
      ST_FIN   = 7'b0010000,
      ST_FHELD = 7'b0100000,
      ST_CLOSE = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      MODE_SCAN    = 3'b001,
      MODE_COLLECT = 3'b010,
      MODE_SKIP    = 3'b100
   } mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [HASH_W-1:0] win_ff, win_in;
   logic [1:0]        held_ff, held_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [1:0]        skip_ff, skip_in;
   logic [ADDR_W-1:0] cs_ff, cs_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [1:0]        idx_ff, idx_in;
   logic              fl_ff, fl_in;
   logic              eob_ff, eob_in;

   // single-byte step
   logic [BYTE_W-1:0] src_byte;
   logic [HASH_W-1:0] scan_v;
   logic [CNT_W-1:0]  cnt_inc;
   logic [HASH_W-1:0] hash_mix;
   mode_type          s_mode;
   logic [HASH_W-1:0] s_win;
   logic [1:0]        s_held;
   logic [CNT_W-1:0]  s_cnt;
   logic [HASH_W-1:0] s_hash;
   logic [1:0]        s_skip;
   logic              s_emit, s_bnd, s_mis, s_mark;
   logic [BYTE_W-1:0] s_byte;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] rd_data;
   logic [ADDR_W-1:0] rp_nxt;

   mbs_cand_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (mem_re),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign src_byte = (state_ff == ST_RP) ? rd_data : req_tdata;
   assign wr_addr  = cs_ff + ADDR_W'(cnt_ff);
   assign rp_nxt   = rp_ff + 1'b1;

   always_comb begin
      scan_v   = win_ff | {{(HASH_W-BYTE_W){1'b0}}, src_byte};
      cnt_inc  = cnt_ff + 1'b1;
      hash_mix = hash_ff ^ (HASH_MUL * {{(HASH_W-BYTE_W){1'b0}}, src_byte});
      s_mode   = mode_ff;
      s_win    = win_ff;
      s_held   = held_ff;
      s_cnt    = cnt_ff;
      s_hash   = hash_ff;
      s_skip   = skip_ff;
      s_emit   = 1'b0;
      s_byte   = '0;
      s_bnd    = 1'b0;
      s_mis    = 1'b0;
      s_mark   = 1'b0;
      case (mode_ff)
         MODE_COLLECT: begin
            if (cnt_inc >= eff_len) begin
               s_cnt  = '0;
               s_hash = '0;
               s_emit = 1'b1;
               if (hash_mix == bnd_hash) begin
                  s_bnd  = 1'b1;
                  s_mode = MODE_SKIP;
                  s_skip = 2'd2;
               end else begin
                  // release the marker, first byte now, rest from ST_MARK
                  s_byte = mbs_marker_byte(2'd0);
                  s_mis  = 1'b1;
                  s_mode = MODE_SCAN;
                  s_win  = '0;
                  s_held = '0;
               end
            end else begin
               s_cnt  = cnt_inc;
               s_hash = hash_mix;
            end
         end
         MODE_SKIP: begin
            if (skip_ff != 2'd0) begin
               s_skip = skip_ff - 1'b1;
            end
            if (s_skip == 2'd0) begin
               s_mode = MODE_SCAN;
               s_win  = '0;
               s_held = '0;
            end
         end
         default: begin
            if (scan_v == MARKER) begin
               s_mark = 1'b1;
               s_held = '0;
               s_win  = '0;
               s_mode = MODE_COLLECT;
               s_cnt  = '0;
               s_hash = '0;
            end else begin
               if (held_ff == 2'd3) begin
                  s_emit = 1'b1;
                  s_byte = scan_v[HASH_W-1 -: BYTE_W];
               end else begin
                  s_held = held_ff + 1'b1;
               end
               s_win = {scan_v[HASH_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            end
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      win_in     = win_ff;
      held_in    = held_ff;
      cnt_in     = cnt_ff;
      hash_in    = hash_ff;
      skip_in    = skip_ff;
      cs_in      = cs_ff;
      rp_in      = rp_ff;
      tail_in    = tail_ff;
      idx_in     = idx_ff;
      fl_in      = fl_ff;
      eob_in     = eob_ff;
      cmd        = '0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = room;
            if (req_tvalid && room) begin
               mode_in = s_mode;
               win_in  = s_win;
               held_in = s_held;
               cnt_in  = s_cnt;
               hash_in = s_hash;
               skip_in = s_skip;
               mem_we  = (mode_ff == MODE_COLLECT);
               eob_in  = req_tlast;
               cmd.emit        = s_emit;
               cmd.out_byte    = s_byte;
               cmd.is_boundary = s_bnd;
               if (s_mis) begin
                  rp_in    = cs_ff;
                  tail_in  = wr_addr + 1'b1;
                  idx_in   = 2'd1;
                  state_in = ST_MARK;
               end else begin
                  if (s_mark) begin
                     cs_in = '0;
                  end
                  if (req_tlast) begin
                     state_in = ST_FIN;
                  end else begin
                     cmd.close = 1'b1;
                  end
               end
            end
         end
         ST_MARK: begin
            if (room) begin
               cmd.emit     = 1'b1;
               cmd.out_byte = mbs_marker_byte(idx_ff);
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  if (fl_ff) begin
                     rp_in   = cs_ff;
                     tail_in = wr_addr;
                     state_in = (cnt_ff == '0) ? ST_CLOSE : ST_RD;
                  end else begin
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            mem_re   = 1'b1;
            state_in = ST_RP;
         end
         ST_RP: begin
            if (room) begin
               rp_in = rp_nxt;
               if (fl_ff) begin
                  cmd.emit     = 1'b1;
                  cmd.out_byte = rd_data;
                  state_in     = (rp_nxt == tail_ff) ? ST_CLOSE : ST_RD;
               end else begin
                  mode_in = s_mode;
                  win_in  = s_win;
                  held_in = s_held;
                  cnt_in  = s_cnt;
                  hash_in = s_hash;
                  skip_in = s_skip;
                  cmd.emit        = s_emit;
                  cmd.out_byte    = s_byte;
                  cmd.is_boundary = s_bnd;
                  if (s_mis) begin
                     // rescan again from the start of these candidates
                     rp_in    = cs_ff;
                     idx_in   = 2'd1;
                     state_in = ST_MARK;
                  end else begin
                     if (s_mark) begin
                        cs_in = rp_nxt;
                     end
                     if (rp_nxt == tail_ff) begin
                        if (eob_ff) begin
                           state_in = ST_FIN;
                        end else begin
                           cmd.close = 1'b1;
                           state_in  = ST_IDLE;
                        end
                     end else begin
                        state_in = ST_RD;
                     end
                  end
               end
            end
         end
         ST_FIN: begin
            if (mode_ff == MODE_COLLECT) begin
               fl_in    = 1'b1;
               idx_in   = 2'd0;
               state_in = ST_MARK;
            end else if (mode_ff == MODE_SCAN && held_ff != 2'd0) begin
               state_in = ST_FHELD;
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_FHELD: begin
            if (room) begin
               cmd.emit = 1'b1;
               case (held_ff)
                  2'd3:    cmd.out_byte = win_ff[31:24];
                  2'd2:    cmd.out_byte = win_ff[23:16];
                  2'd1:    cmd.out_byte = win_ff[15:8];
                  default: cmd.out_byte = '0;
               endcase
               held_in = held_ff - 1'b1;
               if (held_ff == 2'd1) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (room) begin
               cmd.close = 1'b1;
               mode_in   = MODE_SCAN;
               win_in    = WINDOW_INIT;
               held_in   = '0;
               cnt_in    = '0;
               hash_in   = '0;
               skip_in   = '0;
               cs_in     = '0;
               fl_in     = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_SCAN;
         win_ff   <= WINDOW_INIT;
         held_ff  <= '0;
         cnt_ff   <= '0;
         hash_ff  <= '0;
         skip_ff  <= '0;
         cs_ff    <= '0;
         rp_ff    <= '0;
         tail_ff  <= '0;
         idx_ff   <= '0;
         fl_ff    <= 1'b0;
         eob_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         win_ff   <= win_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         hash_ff  <= hash_in;
         skip_ff  <= skip_in;
         cs_ff    <= cs_in;
         rp_ff    <= rp_in;
         tail_ff  <= tail_in;
         idx_ff   <= idx_in;
         fl_ff    <= fl_in;
         eob_ff   <= eob_in;
      end
   end

endmodule
